// File: design/rlpm_pkg.sv
`default_nettype none
package rlpm_pkg;

  localparam int unsigned FracBits  = 16;
  localparam int unsigned RankBits  = 16;
  localparam int unsigned MaxTopics = 4096;
  localparam int unsigned Points    = 11;
  localparam int unsigned FracW     = FracBits + 1;
  localparam int unsigned SumW      = 29;
  localparam int unsigned CntW      = 13;
  localparam int unsigned QDepth    = 2;
  localparam int unsigned DivW      = 32;

  localparam logic [FracW-1:0] OneQ = FracW'(1) << FracBits;
  localparam logic [SumW-1:0] SumMax = SumW'(MaxTopics) << FracBits;
  localparam logic [RankBits-1:0] RankMax = '1;
  localparam logic [CntW-1:0] TopicMax = CntW'(MaxTopics);
  localparam logic [3:0] LastPoint = 4'(Points - 1);

  // Word passed from the front (capture) to the back (compute)
  typedef struct packed {
    logic                is_relevant;
    logic                topic_assessed;
    logic [RankBits-1:0] stated_rank;
    logic [RankBits-1:0] topic_relevant_total;
    logic                topic_last;
  } item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_OPEN,
    ST_RR,
    ST_PREC,
    ST_IDX,
    ST_WALK,
    ST_CHECK,
    ST_AP,
    ST_SUM,
    ST_EMIT
  } back_state_e;

  localparam logic [1:0] AddrPosMode = 2'd0;

endpackage
`default_nettype wire

// File: design/rlpm_div.sv
`default_nettype none
// Restoring divider, one quotient bit a cycle
module rlpm_div
  import rlpm_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire logic [DivW-1:0] num_i,
  input  wire logic [DivW-1:0] den_i,
  output logic                 busy_o,
  output logic [DivW-1:0]      quo_o
);

  logic [DivW-1:0] quo_q, quo_d;
  logic [DivW-1:0] rem_q, rem_d;
  logic [DivW-1:0] den_q, den_d;
  logic [5:0]      cnt_q, cnt_d;
  logic [DivW:0]   trial;

  always_comb begin
    quo_d = quo_q;
    rem_d = rem_q;
    den_d = den_q;
    cnt_d = cnt_q;
    trial = {rem_q, quo_q[DivW-1]} - {1'b0, den_q};
    if (start_i) begin
      quo_d = num_i;
      rem_d = '0;
      den_d = den_i;
      cnt_d = 6'(DivW);
    end else if (cnt_q != '0) begin
      // shift in the next bit, subtract when it fits
      if (!trial[DivW]) begin
        rem_d = trial[DivW-1:0];
        quo_d = {quo_q[DivW-2:0], 1'b1};
      end else begin
        rem_d = {rem_q[DivW-2:0], quo_q[DivW-1]};
        quo_d = {quo_q[DivW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign busy_o = (cnt_q != '0);
  assign quo_o  = quo_q;

endmodule
`default_nettype wire

// File: design/rlpm_front.sv
`default_nettype none
// Accept words and hold them in a short queue for the back end
module rlpm_front
  import rlpm_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  in_valid_i,
  output logic       in_ready_o,
  input  wire item_t in_item_i,
  output logic       q_valid_o,
  input  wire logic  q_pop_i,
  output item_t      q_item_o
);

  item_t      mem_q [QDepth];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign in_ready_o = (cnt_q != 2'(QDepth));
  assign push       = in_valid_i && in_ready_o;
  assign pop        = q_pop_i && q_valid_o;
  assign q_valid_o  = (cnt_q != '0);
  assign q_item_o   = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= in_item_i;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      if (push) wptr_q <= ~wptr_q;
      if (pop)  rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= 2'(QDepth))
    else $error("queue overfilled");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> (wptr_q == rptr_q))
    else $error("pointers differ on empty queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> (cnt_q == $past(cnt_q) + 2'd1))
    else $error("fill count missed a push");

endmodule
`default_nettype wire

// File: design/rlpm_back.sv
`default_nettype none
// Per-topic and run metrics, one word at a time
module rlpm_back
  import rlpm_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             position_mode_i,
  input  wire logic             q_valid_i,
  output logic                  q_pop_o,
  input  wire item_t            q_item_i,
  output logic                  m_valid_o,
  input  wire logic             m_ready_i,
  output logic [3:0]            recall_index_o,
  output logic [SumW-1:0]       interp_sum_o,
  output logic [FracW-1:0]      topic_ap_o,
  output logic [SumW-1:0]       ap_sum_o,
  output logic [SumW-1:0]       rr_sum_o,
  output logic [31:0]           found_total_o,
  output logic [CntW-1:0]       topics_o,
  output logic [CntW-1:0]       assessed_o
);

  back_state_e          state_q, state_d;
  logic                 in_topic_q;
  logic [RankBits-1:0]  pos_q;
  logic [RankBits-1:0]  found_q;
  logic [31:0]          psum_q;
  logic [FracW-1:0]     curve_q [Points];
  logic [SumW-1:0]      run_curve_q [Points];
  logic [SumW-1:0]      ap_sum_q, rr_sum_q;
  logic [31:0]          ftot_q;
  logic [CntW-1:0]      tcnt_q, acnt_q;
  logic [FracW-1:0]     prec_q, ap_q;
  logic [3:0]           pt_q;
  logic                 div_go_q;
  logic                 div_start, div_busy;
  logic [DivW-1:0]      div_num, div_den, div_quo;
  logic [RankBits-1:0]  rank;
  logic [FracW-1:0]     frac_sat;
  logic [FracW-1:0]     ap_sat;
  logic [32:0]          psum_wide;
  logic [31:0]          psum_sat;
  item_t                it;

  // Add a fraction to a run sum, clamp at the run ceiling
  function automatic logic [SumW-1:0] sat_sum(input logic [SumW-1:0] a,
                                              input logic [FracW-1:0] b);
    logic [SumW:0] s;
    s = {1'b0, a} + (SumW+1)'(b);
    return (s > (SumW+1)'(SumMax)) ? SumMax : s[SumW-1:0];
  endfunction

  assign it   = q_item_i;
  assign rank = position_mode_i ? it.stated_rank : pos_q;

  // Saturate a quotient to one, rank zero reads as one
  always_comb begin
    if (rank == '0) frac_sat = OneQ;
    else if (div_quo > DivW'(OneQ)) frac_sat = OneQ;
    else frac_sat = div_quo[FracW-1:0];
  end

  // Average precision quotient, clamped to one
  assign ap_sat = (div_quo > DivW'(OneQ)) ? OneQ : div_quo[FracW-1:0];

  // Precision sum, held at all ones on overflow
  assign psum_wide = {1'b0, psum_q} + 33'(frac_sat);
  assign psum_sat  = psum_wide[32] ? '1 : psum_wide[31:0];

  rlpm_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (div_den),
    .busy_o (div_busy),
    .quo_o  (div_quo)
  );

  // Divider operands per state
  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = DivW'(rank);
    unique case (state_q)
      ST_RR:   div_num = DivW'(1) << FracBits;
      ST_PREC: div_num = DivW'(found_q) << FracBits;
      ST_IDX:  begin
        div_num = DivW'(found_q) * DivW'(10);
        div_den = DivW'(it.topic_relevant_total);
      end
      ST_AP:   begin
        div_num = psum_q;
        div_den = DivW'(it.topic_relevant_total);
      end
      default: ;
    endcase
    if (state_q == ST_RR || state_q == ST_PREC || state_q == ST_IDX
        || state_q == ST_AP) begin
      div_start = !div_go_q;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    q_pop_o = 1'b0;
    unique case (state_q)
      ST_IDLE: if (q_valid_i) state_d = ST_OPEN;
      ST_OPEN: state_d = !it.is_relevant ? ST_CHECK :
                         (found_q == '0) ? ST_RR : ST_PREC;
      ST_RR:   if (div_go_q && !div_busy) state_d = ST_PREC;
      ST_PREC: if (div_go_q && !div_busy) state_d = ST_IDX;
      ST_IDX:  if (div_go_q && !div_busy) state_d = ST_WALK;
      ST_WALK: if (pt_q == '0 || curve_q[pt_q] >= prec_q) state_d = ST_CHECK;
      ST_CHECK: begin
        if (!it.topic_last) begin
          q_pop_o = 1'b1;
          state_d = ST_IDLE;
        end else if (it.topic_relevant_total == '0) begin
          state_d = ST_EMIT;
        end else begin
          state_d = ST_AP;
        end
      end
      ST_AP:   if (div_go_q && !div_busy) state_d = ST_SUM;
      ST_SUM:  if (pt_q == LastPoint) state_d = ST_EMIT;
      ST_EMIT: if (m_ready_i && pt_q == LastPoint) begin
        q_pop_o = 1'b1;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Update the topic and run state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_topic_q <= 1'b0;
      pos_q      <= '0;
      found_q    <= '0;
      psum_q     <= '0;
      ap_sum_q   <= '0;
      rr_sum_q   <= '0;
      ftot_q     <= '0;
      tcnt_q     <= '0;
      acnt_q     <= '0;
      div_go_q   <= 1'b0;
      pt_q       <= '0;
      prec_q     <= '0;
      ap_q       <= '0;
      for (int i = 0; i < Points; i++) begin
        curve_q[i]     <= '0;
        run_curve_q[i] <= '0;
      end
    end else begin
      div_go_q <= (state_d == state_q) && (state_q == ST_RR || state_q == ST_PREC
                  || state_q == ST_IDX || state_q == ST_AP);
      unique case (state_q)
        ST_IDLE: if (q_valid_i) begin
          if (!in_topic_q) begin
            in_topic_q <= 1'b1;
            found_q    <= '0;
            psum_q     <= '0;
            pos_q      <= RankBits'(1);
            for (int i = 0; i < Points; i++) curve_q[i] <= '0;
            if (tcnt_q != TopicMax) tcnt_q <= tcnt_q + CntW'(1);
            if (it.topic_assessed && acnt_q != TopicMax) acnt_q <= acnt_q + CntW'(1);
          end else if (pos_q != RankMax) begin
            pos_q <= pos_q + RankBits'(1);
          end
        end
        ST_OPEN: if (it.is_relevant) begin
          if (ftot_q != '1) ftot_q <= ftot_q + 32'd1;
          if (found_q != RankMax) found_q <= found_q + RankBits'(1);
        end
        ST_RR: if (div_go_q && !div_busy) begin
          rr_sum_q <= sat_sum(rr_sum_q, frac_sat);
        end
        ST_PREC: if (div_go_q && !div_busy) begin
          prec_q <= frac_sat;
          psum_q <= psum_sat;
        end
        ST_IDX: if (div_go_q && !div_busy) begin
          if (it.topic_relevant_total == '0 || div_quo > DivW'(10)) pt_q <= 4'd10;
          else pt_q <= div_quo[3:0];
        end
        ST_WALK: if (curve_q[pt_q] < prec_q) begin
          curve_q[pt_q] <= prec_q;
          if (pt_q != '0) pt_q <= pt_q - 4'd1;
        end
        ST_CHECK: begin
          pt_q <= '0;
          ap_q <= '0;
          if (it.topic_last) in_topic_q <= 1'b0;
        end
        ST_AP: if (div_go_q && !div_busy) begin
          ap_q     <= ap_sat;
          ap_sum_q <= sat_sum(ap_sum_q, ap_sat);
        end
        ST_SUM: begin
          run_curve_q[pt_q] <= sat_sum(run_curve_q[pt_q], curve_q[pt_q]);
          pt_q <= (pt_q == LastPoint) ? '0 : pt_q + 4'd1;
        end
        ST_EMIT: if (m_ready_i) begin
          pt_q <= (pt_q == LastPoint) ? '0 : pt_q + 4'd1;
        end
        default: ;
      endcase
    end
  end

  assign m_valid_o      = (state_q == ST_EMIT);
  assign recall_index_o = pt_q;
  assign interp_sum_o   = run_curve_q[pt_q];
  assign topic_ap_o     = ap_q;
  assign ap_sum_o       = ap_sum_q;
  assign rr_sum_o       = rr_sum_q;
  assign found_total_o  = ftot_q;
  assign topics_o       = tcnt_q;
  assign assessed_o     = acnt_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_o |-> (pt_q <= LastPoint))
    else $error("emit index out of range");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_o && !m_ready_i) |=> (m_valid_o && $stable(pt_q)))
    else $error("stalled word changed");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> q_valid_i)
    else $error("pop from empty queue");

endmodule
`default_nettype wire

// File: design/ranked_list_precision_metrics_core.sv
`default_nettype none
// Ranked list precision metrics core.
// s_axis carries judged results of a ranked run, grouped by topic; tlast
// marks a topic's final result. For each closed topic m_axis delivers 11
// words, one per recall point, with the run sums; tlast marks the 11th.
// The APB port holds position_mode at address 0 (0 list position, 1 the
// stated rank); write it only while idle.
// Flow: a two-word queue takes input while the back end works. The back
// end handles one word at a time, set by the single shared serial divider:
// a non-relevant word needs no division, a relevant one two divisions plus
// a walk of the recall curve, and the first relevant word of a topic three
// divisions plus the walk; a topic end adds one more division and a summing
// pass over the 11 points (neither when the relevant total is zero) and
// then the 11 output words.
// Reset clears all run and topic sums and the queue. A stalled m_axis holds
// its word and the back end waits; the queue then fills and s_axis_tready
// drops.
module ranked_list_precision_metrics_core
  import rlpm_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // tdata: [0] is_relevant, [1] topic_assessed, [17:2] stated_rank,
  //        [33:18] topic_relevant_total, zero fill to 40
  input  wire logic [39:0]  s_axis_tdata,
  input  wire logic         s_axis_tlast,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // tdata: [3:0] recall_index, [32:4] interp_precision_sum,
  //   [49:33] topic_average_precision, [78:50] average_precision_sum,
  //   [107:79] reciprocal_rank_sum, [139:108] relevant_retrieved,
  //   [152:140] topics_seen, [165:153] assessed_topics_seen, zero fill to 168
  output logic [167:0]      m_axis_tdata,
  output logic              m_axis_tlast,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [1:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic posmode_q;
  item_t in_item, q_item;
  logic q_valid, q_pop;
  logic [3:0] ri;
  logic [SumW-1:0] isum, apsum, rrsum;
  logic [FracW-1:0] tap;
  logic [31:0] ftot;
  logic [CntW-1:0] tcnt, acnt;

  // Register write
  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      posmode_q <= 1'b0;
    end else if (psel && penable && pwrite && paddr == AddrPosMode) begin
      posmode_q <= pwdata[0];
    end
  end
  assign prdata = (paddr == AddrPosMode) ? {31'd0, posmode_q} : '0;

  assign in_item.is_relevant          = s_axis_tdata[0];
  assign in_item.topic_assessed       = s_axis_tdata[1];
  assign in_item.stated_rank          = s_axis_tdata[17:2];
  assign in_item.topic_relevant_total = s_axis_tdata[33:18];
  assign in_item.topic_last           = s_axis_tlast;

  rlpm_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready),
    .in_item_i (in_item),
    .q_valid_o (q_valid),
    .q_pop_i   (q_pop),
    .q_item_o  (q_item)
  );

  rlpm_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .position_mode_i(posmode_q),
    .q_valid_i      (q_valid),
    .q_pop_o        (q_pop),
    .q_item_i       (q_item),
    .m_valid_o      (m_axis_tvalid),
    .m_ready_i      (m_axis_tready),
    .recall_index_o (ri),
    .interp_sum_o   (isum),
    .topic_ap_o     (tap),
    .ap_sum_o       (apsum),
    .rr_sum_o       (rrsum),
    .found_total_o  (ftot),
    .topics_o       (tcnt),
    .assessed_o     (acnt)
  );

  assign m_axis_tdata = {2'b00, acnt, tcnt, ftot, rrsum, apsum, tap, isum, ri};
  assign m_axis_tlast = (ri == LastPoint);

endmodule
`default_nettype wire

// File: tb/ranked_list_precision_metrics_core_tb.sv
module ranked_list_precision_metrics_core_tb
  import rlpm_pkg::*;
();

  typedef struct packed {
    logic [3:0]  recall_index;
    logic [28:0] interp_precision_sum;
    logic [16:0] topic_average_precision;
    logic [28:0] average_precision_sum;
    logic [28:0] reciprocal_rank_sum;
    logic [31:0] relevant_retrieved;
    logic [12:0] topics_seen;
    logic [12:0] assessed_topics_seen;
    logic        burst_last;
  } metric_word_t;

  int unsigned fail_count = 0;

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d want %0d", what, got, want);
    fail_count++;
  endtask

  // Scoreboard: predicts the metric words per topic and checks them in order
  class metrics_scoreboard;
    bit          pos_mode;
    bit          in_topic;
    longint      list_pos, found, prec_sum, recip;
    longint      curve[11];
    longint      run_curve[11];
    longint      run_ap, run_rr, run_found, topic_cnt, assessed_cnt;
    metric_word_t pending[$];

    function longint frac_of(longint num, longint den);
      longint q;
      if (den == 0) return 65536;
      q = (num * 65536) / den;
      return (q > 65536) ? 65536 : q;
    endfunction

    function longint sat(longint a, longint b, longint cap);
      return (a + b > cap) ? cap : a + b;
    endfunction

    function void note_item(item_t it);
      longint pos, prec, idx, ap;
      metric_word_t w;
      ap = 0;
      if (!in_topic) begin
        in_topic = 1; list_pos = 0; found = 0; prec_sum = 0; recip = 0;
        foreach (curve[p]) curve[p] = 0;
        topic_cnt = sat(topic_cnt, 1, 4096);
        if (it.topic_assessed) assessed_cnt = sat(assessed_cnt, 1, 4096);
      end
      list_pos = sat(list_pos, 1, 65535);
      if (it.is_relevant) begin
        pos = pos_mode ? longint'(it.stated_rank) : list_pos;
        run_found = sat(run_found, 1, 64'hFFFF_FFFF);
        if (found == 0) begin
          recip = frac_of(1, pos);
          run_rr = sat(run_rr, recip, 4096 * 65536);
        end
        found = sat(found, 1, 65535);
        prec = frac_of(found, pos);
        prec_sum = sat(prec_sum, prec, 64'hFFFF_FFFF);
        if (it.topic_relevant_total == 0) idx = 10;
        else begin
          idx = (found * 10) / it.topic_relevant_total;
          if (idx > 10) idx = 10;
        end
        for (int p = int'(idx); p >= 0; p--) begin
          if (curve[p] < prec) curve[p] = prec;
          else break;
        end
      end
      if (!it.topic_last) return;
      if (it.topic_relevant_total != 0) begin
        ap = prec_sum / it.topic_relevant_total;
        if (ap > 65536) ap = 65536;
        run_ap = sat(run_ap, ap, 4096 * 65536);
        foreach (run_curve[p]) run_curve[p] = sat(run_curve[p], curve[p], 4096 * 65536);
      end
      in_topic = 0;
      for (int k = 0; k < 11; k++) begin
        w.recall_index = 4'(k);
        w.interp_precision_sum = 29'(run_curve[k]);
        w.topic_average_precision = 17'(ap);
        w.average_precision_sum = 29'(run_ap);
        w.reciprocal_rank_sum = 29'(run_rr);
        w.relevant_retrieved = 32'(run_found);
        w.topics_seen = 13'(topic_cnt);
        w.assessed_topics_seen = 13'(assessed_cnt);
        w.burst_last = (k == 10);
        pending.push_back(w);
      end
    endfunction

    task check_word(logic [167:0] d, logic last);
      metric_word_t e;
      if (pending.size() == 0) begin
        report_mismatch("unexpected word", d[3:0], -1);
        return;
      end
      e = pending.pop_front();
      if (d[3:0] !== e.recall_index) report_mismatch("recall_index", d[3:0], e.recall_index);
      if (d[32:4] !== e.interp_precision_sum)
        report_mismatch("interp_precision_sum", d[32:4], e.interp_precision_sum);
      if (d[49:33] !== e.topic_average_precision)
        report_mismatch("topic_average_precision", d[49:33], e.topic_average_precision);
      if (d[78:50] !== e.average_precision_sum)
        report_mismatch("average_precision_sum", d[78:50], e.average_precision_sum);
      if (d[107:79] !== e.reciprocal_rank_sum)
        report_mismatch("reciprocal_rank_sum", d[107:79], e.reciprocal_rank_sum);
      if (d[139:108] !== e.relevant_retrieved)
        report_mismatch("relevant_retrieved", d[139:108], e.relevant_retrieved);
      if (d[152:140] !== e.topics_seen) report_mismatch("topics_seen", d[152:140], e.topics_seen);
      if (d[165:153] !== e.assessed_topics_seen)
        report_mismatch("assessed_topics_seen", d[165:153], e.assessed_topics_seen);
      if (last !== e.burst_last) report_mismatch("burst_last", last, e.burst_last);
    endtask
  endclass

  logic clk_i = 0, rst_ni = 0;
  logic s_axis_tvalid = 0, s_axis_tready, s_axis_tlast = 0;
  logic [39:0] s_axis_tdata = '0;
  logic m_axis_tvalid, m_axis_tready = 0, m_axis_tlast;
  logic [167:0] m_axis_tdata;
  logic psel = 0, penable = 0, pwrite = 0, pready;
  logic [1:0] paddr = '0;
  logic [31:0] pwdata = '0, prdata;
  longint cycles = 0;
  metrics_scoreboard sb = new();

  ranked_list_precision_metrics_core dut (.*);

  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  // Limit the run
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > 2_000_000) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Check every accepted result word
  always @(posedge clk_i)
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_word(m_axis_tdata, m_axis_tlast);

  // Receiver: random stalls, with a quiet stretch in the middle
  initial begin
    int gap;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      gap = (cycles > 40000 && cycles < 80000) ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
        m_axis_tready <= 0;
        repeat (gap) @(negedge clk_i);
      end
      m_axis_tready <= 1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
    end
  end

  task automatic write_pos_mode(input bit mode);
    @(negedge clk_i);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= AddrPosMode; pwdata <= 32'(mode);
    @(negedge clk_i);
    penable <= 1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    sb.pos_mode = mode;
    @(negedge clk_i);
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  // Hold off until the block has drained
  task automatic drain;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic send_item(input item_t it, input bit nogap);
    if (!nogap) repeat ($urandom_range(0, 7)) @(negedge clk_i);
    @(negedge clk_i);
    s_axis_tvalid <= 1;
    s_axis_tdata <= {6'b0, it.topic_relevant_total, it.stated_rank,
                     it.topic_assessed, it.is_relevant};
    s_axis_tlast <= it.topic_last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_item(it);
    @(negedge clk_i);
    s_axis_tvalid <= 0;
  endtask

  function automatic item_t mk(bit rel, bit ass, int rank, int total, bit last);
    item_t it;
    it.is_relevant = rel; it.topic_assessed = ass; it.stated_rank = 16'(rank);
    it.topic_relevant_total = 16'(total); it.topic_last = last;
    return it;
  endfunction

  // Send one topic of random length, with mostly ascending ranks and random jumps
  task automatic send_topic(input int len);
    int total, rank;
    bit ass;
    total = ($urandom_range(0, 9) == 0) ? 0 :
            ($urandom_range(0, 15) == 0) ? $urandom_range(1, 65535) : $urandom_range(1, 8);
    ass = $urandom_range(0, 1);
    rank = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535) : 1;
    for (int i = 0; i < len; i++) begin
      send_item(mk($urandom_range(0, 1), ass, rank, total, i == len - 1), 0);
      rank = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535) : rank + 1;
    end
  endtask

  initial begin
    int sent;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1;
    write_pos_mode(0);
    // Directed: first relevant, zero total, recall above one, rank extremes
    send_item(mk(0, 1, 1, 2, 0), 0);
    send_item(mk(1, 1, 2, 2, 0), 0);
    send_item(mk(1, 1, 3, 2, 0), 0);
    send_item(mk(1, 1, 4, 2, 1), 0);
    send_item(mk(1, 0, 65535, 0, 1), 0);
    send_item(mk(0, 0, 1, 65535, 1), 0);
    send_item(mk(1, 1, 1, 65535, 0), 0);
    send_item(mk(1, 1, 1, 1, 1), 0);
    drain();
    write_pos_mode(1);
    send_item(mk(1, 1, 0, 3, 0), 0);
    send_item(mk(1, 1, 65535, 3, 0), 0);
    send_item(mk(1, 0, 2, 3, 0), 0);
    send_item(mk(1, 0, 1, 3, 1), 0);
    send_item(mk(0, 1, 32768, 0, 1), 1);
    send_item(mk(1, 1, 5, 1, 0), 1);
    send_item(mk(0, 1, 2, 1, 1), 1);
    drain();
    // Random: alternate modes between drained phases
    sent = 15;
    for (int ph = 0; ph < 4; ph++) begin
      write_pos_mode(ph[0]);
      while (sent < 15 + (ph + 1) * 80) begin
        int len;
        len = $urandom_range(1, 10);
        send_topic(len);
        sent += len;
      end
      drain();
    end
    write_pos_mode(0);
    drain();
    if (fail_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end
endmodule

// File: files.f
design/rlpm_pkg.sv
design/rlpm_div.sv
design/rlpm_front.sv
design/rlpm_back.sv
design/ranked_list_precision_metrics_core.sv
tb/ranked_list_precision_metrics_core_tb.sv
